// ===== rtl/tprc_pkg.sv =====
`timescale 1ns / 1ps

package tprc_pkg;

    // Fixed point format of the curve arithmetic
    localparam int FRAC_BITS = 12;
    localparam int ONE_VAL   = 1 << FRAC_BITS;

    // Port field widths
    localparam int SLOT_W     = 4;
    localparam int RAW_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int BLEND_W    = 13;
    localparam int SP_W       = 17;
    localparam int SD_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Gain stage
    localparam int PROD_W      = RAW_W + GAIN_W + 1;
    localparam int DELTA_SHIFT = 3;
    localparam int P_TOP       = 4 * ONE_VAL;
    localparam int D_TOP       = ONE_VAL;

    // Curve operands
    localparam int X_W    = FRAC_BITS + 3;
    localparam int ROOT_W = FRAC_BITS + 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SQ_W   = FRAC_BITS + 5;
    localparam int W_W    = FRAC_BITS + 1;
    localparam int A_W    = SQ_W;
    localparam int B_W    = X_W;
    localparam int PA_W   = A_W + W_W;
    localparam int PB_W   = B_W + W_W;
    localparam int SUM_W  = PA_W + 1;

    // Lanes: pressure and pressure change travel side by side
    localparam int LANES  = 2;
    localparam int LANE_P = 0;
    localparam int LANE_D = 1;

    // Pipeline depth
    localparam int SCALE_STG = 2;
    localparam int CURVE_STG = 3;
    localparam int NSTG      = SCALE_STG + ROOT_W + CURVE_STG;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSURE_GAIN = 2'd0,
        CFG_CURVE_BLEND   = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        logic                          sq_mode;
        logic [W_W-1:0]                w_a;
        logic [W_W-1:0]                w_b;
    } blend_t;

    typedef struct packed {
        logic [SLOT_W-1:0]             slot;
        logic [LANES-1:0][X_W-1:0]     x;
    } scaled_t;

    typedef struct packed {
        logic [SLOT_W-1:0]             slot;
        logic [LANES-1:0][X_W-1:0]     x;
        logic [LANES-1:0][ROOT_W-1:0]  r;
    } root_t;

    typedef struct packed {
        logic [SLOT_W-1:0]             slot;
        logic [SP_W-1:0]               pressure;
        logic [SD_W-1:0]               delta;
    } result_t;

endpackage

// ===== rtl/tprc_if.sv =====
`timescale 1ns / 1ps

interface tprc_touch_if import tprc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SLOT_W-1:0]        touch_slot;
    logic signed [RAW_W-1:0]  touch_pressure;
    logic signed [RAW_W-1:0]  pressure_delta;

    modport source (output valid, touch_slot, touch_pressure, pressure_delta, input ready);
    modport sink   (input valid, touch_slot, touch_pressure, pressure_delta, output ready);
endinterface

interface tprc_result_if import tprc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SLOT_W-1:0]        slot_out;
    logic [SP_W-1:0]          shaped_pressure;
    logic [SD_W-1:0]          shaped_delta;

    modport source (output valid, slot_out, shaped_pressure, shaped_delta, input ready);
    modport sink   (input valid, slot_out, shaped_pressure, shaped_delta, output ready);
endinterface

interface tprc_cfg_if import tprc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/touch_pressure_response_curve_core.sv =====
`timescale 1ns / 1ps

// Channel   Role    Handshake      Payload
// touch     sink    valid/ready    touch_slot, touch_pressure, pressure_delta
// result    source  valid/ready    slot_out, shaped_pressure, shaped_delta
// cfg       sink    valid/ready    index, data (0 pressure_gain, 1 curve_blend)
//
// One request per cycle unless all stages are full and the result stalls; NSTG
// sums a 14-stage square root at FRAC_BITS 12, two gain and three curve stages.
// Reset clears the stage valid bits and loads gain 1.0 and a linear curve.
// A stalled result holds the output register; earlier stages keep taking
// requests until every stage is full, so bubbles close up and nothing is lost.
// cfg is always ready; writes take effect at once.

module touch_pressure_response_curve_core import tprc_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    tprc_touch_if.sink     touch,
    tprc_result_if.source  result,
    tprc_cfg_if.sink       cfg
);

    logic [GAIN_W-1:0]   gain_reg;
    logic [BLEND_W-1:0]  blend_reg;
    logic [NSTG-1:0]     valid_reg;
    logic [NSTG-1:0]     valid_next;
    logic [NSTG-1:0]     adv;
    logic [W_W-1:0]      c_sat;
    logic [W_W:0]        two_c;
    logic [W_W-1:0]      t_w;
    blend_t              blend;
    scaled_t             scaled;
    root_t               root;
    result_t             res;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_W'(ONE_VAL);
            blend_reg <= BLEND_W'(ONE_VAL >> 1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PRESSURE_GAIN: gain_reg  <= cfg.data[GAIN_W-1:0];
                CFG_CURVE_BLEND:   blend_reg <= cfg.data[BLEND_W-1:0];
                default:           ;
            endcase
        end
    end

    // Saturate the blend and derive the two curve weights
    always_comb
    begin
        if (int'(blend_reg) > ONE_VAL)
            c_sat = W_W'(ONE_VAL);
        else
            c_sat = W_W'(blend_reg);
        two_c = {c_sat, 1'b0};
        blend.sq_mode = (int'(c_sat) < (ONE_VAL >> 1));
        if (blend.sq_mode)
            t_w = {c_sat[W_W-2:0], 1'b0};
        else
            t_w = W_W'(two_c - (W_W + 1)'(ONE_VAL));
        blend.w_a = W_W'(ONE_VAL) - t_w;
        blend.w_b = t_w;
    end

    // A stage advances when it is empty or some later stage is empty or drains
    for (genvar s = 0; s < NSTG; s++)
    begin : g_adv
        assign adv[s] = result.ready || !(&valid_reg[NSTG-1:s]);
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? touch.valid : valid_reg[0];
        for (int s = 1; s < NSTG; s++)
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign touch.ready = adv[0];

    tprc_scale u_scale (
        .clk            (clk),
        .adv            (adv[SCALE_STG-1:0]),
        .touch_slot     (touch.touch_slot),
        .touch_pressure (touch.touch_pressure),
        .pressure_delta (touch.pressure_delta),
        .gain           (gain_reg),
        .scaled         (scaled)
    );

    tprc_root u_root (
        .clk    (clk),
        .adv    (adv[SCALE_STG +: ROOT_W]),
        .scaled (scaled),
        .root   (root)
    );

    tprc_curve u_curve (
        .clk   (clk),
        .adv   (adv[SCALE_STG+ROOT_W +: CURVE_STG]),
        .blend (blend),
        .root  (root),
        .res   (res)
    );

    // Result register drives the output channel
    assign result.valid           = valid_reg[NSTG-1];
    assign result.slot_out        = res.slot;
    assign result.shaped_pressure = res.pressure;
    assign result.shaped_delta    = res.delta;

endmodule

// ===== rtl/tprc_scale.sv =====
`timescale 1ns / 1ps

module tprc_scale import tprc_pkg::*; (
    input  logic                    clk,
    input  logic [SCALE_STG-1:0]    adv,
    input  logic [SLOT_W-1:0]       touch_slot,
    input  logic signed [RAW_W-1:0] touch_pressure,
    input  logic signed [RAW_W-1:0] pressure_delta,
    input  logic [GAIN_W-1:0]       gain,
    output scaled_t                 scaled
);

    localparam int VP_W  = PROD_W - FRAC_BITS;
    localparam int VD_W  = PROD_W - FRAC_BITS - DELTA_SHIFT;
    localparam int CMP_W = PROD_W + X_W;

    logic signed [PROD_W-1:0] prod_p_next;
    logic signed [PROD_W-1:0] prod_d_next;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_d_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [VP_W-1:0]          vp;
    logic [VD_W-1:0]          vd;
    scaled_t                  scaled_next;
    scaled_t                  scaled_reg;

    // Multiply both raw values by the gain
    always_comb
    begin
        prod_p_next = touch_pressure * $signed({1'b0, gain});
        prod_d_next = pressure_delta * $signed({1'b0, gain});
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_p_reg <= prod_p_next;
            prod_d_reg <= prod_d_next;
            slot_reg   <= touch_slot;
        end
    end

    // Drop the fraction, clamp negatives to zero and cap at the lane's top
    always_comb
    begin
        vp = prod_p_reg[PROD_W-1:FRAC_BITS];
        vd = prod_d_reg[PROD_W-1:FRAC_BITS+DELTA_SHIFT];
        scaled_next.slot = slot_reg;

        if (prod_p_reg[PROD_W-1] || prod_p_reg == '0)
            scaled_next.x[LANE_P] = '0;
        else if (CMP_W'(vp) > CMP_W'(P_TOP))
            scaled_next.x[LANE_P] = X_W'(P_TOP);
        else
            scaled_next.x[LANE_P] = X_W'(vp);

        if (prod_d_reg[PROD_W-1] || prod_d_reg == '0)
            scaled_next.x[LANE_D] = '0;
        else if (CMP_W'(vd) > CMP_W'(D_TOP))
            scaled_next.x[LANE_D] = X_W'(D_TOP);
        else
            scaled_next.x[LANE_D] = X_W'(vd);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
            scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

// ===== rtl/tprc_root.sv =====
`timescale 1ns / 1ps

module tprc_root import tprc_pkg::*; (
    input  logic                clk,
    input  logic [ROOT_W-1:0]   adv,
    input  scaled_t             scaled,
    output root_t               root
);

    logic [ROOT_W+1:0]  rem_reg  [ROOT_W][LANES];
    logic [ROOT_W-1:0]  q_reg    [ROOT_W][LANES];
    logic [RAD_W-1:0]   rad_reg  [ROOT_W][LANES];
    logic [X_W-1:0]     x_reg    [ROOT_W][LANES];
    logic [SLOT_W-1:0]  slot_reg [ROOT_W];

    // One root bit per stage, restoring digit recurrence on x << FRAC_BITS
    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stg
        logic [SLOT_W-1:0] slot_in;

        if (s == 0)
        begin : g_first
            assign slot_in = scaled.slot;
        end
        else
        begin : g_next
            assign slot_in = slot_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv[s])
                slot_reg[s] <= slot_in;
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [ROOT_W+1:0] rem_in;
            logic [ROOT_W-1:0] q_in;
            logic [RAD_W-1:0]  rad_in;
            logic [X_W-1:0]    x_in;
            logic [ROOT_W+1:0] shifted;
            logic [ROOT_W+1:0] trial;
            logic [ROOT_W+1:0] rem_next;
            logic [ROOT_W-1:0] q_next;
            logic [RAD_W-1:0]  rad_next;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign q_in   = '0;
                assign rad_in = RAD_W'({scaled.x[l], {FRAC_BITS{1'b0}}});
                assign x_in   = scaled.x[l];
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1][l];
                assign q_in   = q_reg[s-1][l];
                assign rad_in = rad_reg[s-1][l];
                assign x_in   = x_reg[s-1][l];
            end

            // Bring down two radicand bits and try the next root bit
            always_comb
            begin
                shifted  = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
                trial    = {q_in, 2'b01};
                rad_next = {rad_in[RAD_W-3:0], 2'b00};
                if (shifted >= trial)
                begin
                    rem_next = shifted - trial;
                    q_next   = {q_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    q_next   = {q_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    rem_reg[s][l] <= rem_next;
                    q_reg[s][l]   <= q_next;
                    rad_reg[s][l] <= rad_next;
                    x_reg[s][l]   <= x_in;
                end
            end
        end
    end

    // Present the finished roots with their operands
    always_comb
    begin
        root.slot = slot_reg[ROOT_W-1];
        for (int l = 0; l < LANES; l++)
        begin
            root.x[l] = x_reg[ROOT_W-1][l];
            root.r[l] = q_reg[ROOT_W-1][l];
        end
    end

endmodule

// ===== rtl/tprc_curve.sv =====
`timescale 1ns / 1ps

module tprc_curve import tprc_pkg::*; (
    input  logic                  clk,
    input  logic [CURVE_STG-1:0]  adv,
    input  blend_t                blend,
    input  root_t                 root,
    output result_t               res
);

    logic [2*X_W-1:0]              xx [LANES];
    logic [LANES-1:0][SQ_W-1:0]    sq_next;
    logic [LANES-1:0][SQ_W-1:0]    sq_reg;
    root_t                         c0_reg;
    logic [A_W-1:0]                a_op [LANES];
    logic [B_W-1:0]                b_op [LANES];
    logic [LANES-1:0][PA_W-1:0]    pa_next;
    logic [LANES-1:0][PB_W-1:0]    pb_next;
    logic [LANES-1:0][PA_W-1:0]    pa_reg;
    logic [LANES-1:0][PB_W-1:0]    pb_reg;
    logic [SLOT_W-1:0]             slot1_reg;
    logic [SUM_W-1:0]              sum [LANES];
    logic [SUM_W-1:0]              y [LANES];
    result_t                       res_next;
    result_t                       res_reg;

    // Square each operand, keep the Q.12 part
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            xx[l]      = root.x[l] * root.x[l];
            sq_next[l] = xx[l][FRAC_BITS +: SQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sq_reg <= sq_next;
            c0_reg <= root;
        end
    end

    // Pick the two curve end points and weight them
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (blend.sq_mode)
            begin
                a_op[l] = sq_reg[l];
                b_op[l] = c0_reg.x[l];
            end
            else
            begin
                a_op[l] = A_W'(c0_reg.x[l]);
                b_op[l] = B_W'(c0_reg.r[l]);
            end
            pa_next[l] = a_op[l] * blend.w_a;
            pb_next[l] = b_op[l] * blend.w_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            slot1_reg <= c0_reg.slot;
        end
    end

    // Add the weighted halves and truncate to Q.12
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sum[l] = SUM_W'(pa_reg[l]) + SUM_W'(pb_reg[l]);
            y[l]   = sum[l] >> FRAC_BITS;
        end
        res_next.slot     = slot1_reg;
        res_next.pressure = SP_W'(y[LANE_P]);
        res_next.delta    = SD_W'(y[LANE_D]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/tprc_checker.sv =====
`timescale 1ns / 1ps

module tprc_checker import tprc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [SLOT_W-1:0] slot_out,
    input  logic [SP_W-1:0]   shaped_pressure,
    input  logic [SD_W-1:0]   shaped_delta
);

    localparam int CNT_W = $clog2(NSTG + 1) + 1;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Track requests in flight
    always_comb
        cnt_next = cnt_reg + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable({slot_out, shaped_pressure, shaped_delta}))
        else $error("stalled result changed");

    // Back-pressure only when the result side is stalled
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused while output drains");

    // Never more in flight than stages, and no result from an empty pipe
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CNT_W'(NSTG)) && (!out_valid || cnt_reg != '0))
        else $error("in-flight count out of range");

    // Curved outputs stay within their full-scale values
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(shaped_pressure) <= 16 * ONE_VAL)
                   && (int'(shaped_delta) <= ONE_VAL))
        else $error("shaped value beyond full scale");

endmodule

bind touch_pressure_response_curve_core tprc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (touch.valid),
    .in_ready        (touch.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .slot_out        (result.slot_out),
    .shaped_pressure (result.shaped_pressure),
    .shaped_delta    (result.shaped_delta)
);
